[rtl/rrc_pkg.sv]
// Shared types, constants and register codes of the ratiometric resistance calculator.
package rrc_pkg;

  // Field widths
  localparam int RANGE_W = 3;
  localparam int FAULT_W = 4;
  localparam int MV_W    = 13;
  localparam int RREF_W  = 24;
  localparam int GAIN_W  = 18;
  localparam int RES_W   = 44;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Datapath widths
  localparam int RG_W    = RREF_W + GAIN_W;   // rref * gain
  localparam int MVK_W   = 23;                // mv * 1000
  localparam int PP_SPLIT = 21;               // split of rref*gain for partial products
  localparam int PP_W    = (RG_W - PP_SPLIT) + MVK_W;
  localparam int PROD_W  = RG_W + MVK_W;
  localparam int Q16_SHIFT = 16;
  localparam int NUM_W   = PROD_W - Q16_SHIFT; // dividend after the Q16 drop

  // Divider layout: DIV_BITS quotient bits per stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W      = DIV_STAGES * DIV_BITS;

  // Low-range bias datapath
  localparam int BX_W  = 17;   // 100000 - R inside the taper band
  localparam int BY_W  = 18;   // floor(161 * x / 64)
  localparam int BQ_W  = 14;   // floor(y / 25)
  localparam int BM_W  = 34;   // y * reciprocal

  localparam logic [RES_W-1:0]  R_MAX      = {RES_W{1'b1}};
  localparam logic [MVK_W-1:0]  MV_SCALE   = 23'd1000;
  localparam logic [RES_W-1:0]  BIAS_LO_R  = 44'd20000;
  localparam logic [RES_W-1:0]  BIAS_HI_R  = 44'd100000;
  localparam logic [RES_W-1:0]  BIAS_FLAT  = 44'd8050;
  localparam logic [23:0]       BIAS_NUM   = 24'd161;    // 8050/80000 = 161/1600
  localparam int                BIAS_SHIFT = 6;          // 1600 = 64 * 25
  localparam logic [BM_W-1:0]   RECIP_25   = 34'd41943;  // floor(2^20 / 25)
  localparam int                RECIP_SHIFT = 20;
  localparam logic [BY_W-1:0]   BIAS_DIV   = 18'd25;

  // Range select codes
  localparam logic [RANGE_W-1:0] RANGE_AUTO = 3'd0;
  localparam logic [RANGE_W-1:0] RANGE_LOW  = 3'd1;
  localparam logic [RANGE_W-1:0] RANGE_TOP  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RREF1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RREF2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RREF3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RREF4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN4 = 3'd7;

  localparam logic [RREF_W-1:0] RREF1_RST = 24'd1000;
  localparam logic [RREF_W-1:0] RREF2_RST = 24'd10000;
  localparam logic [RREF_W-1:0] RREF3_RST = 24'd100000;
  localparam logic [RREF_W-1:0] RREF4_RST = 24'd1000000;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 18'd65536;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RANGE = 3'd1,
    ST_NOT_IMPL  = 3'd2,
    ST_OVERRANGE = 3'd3,
    ST_FAULT     = 3'd4
  } status_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_select;
    logic               sample_valid;
    logic [FAULT_W-1:0] sample_fault;
    logic [MV_W-1:0]    measured_mv;
    logic [MV_W-1:0]    supply_mv;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [FAULT_W-1:0] fault_echo;
    logic [RES_W-1:0]   resistance_mohm;
  } out_t;

  // Side information that rides along with each request
  typedef struct packed {
    status_t            status;
    logic [FAULT_W-1:0] fault;
    logic               low_range;
  } tag_t;

  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [MV_W-1:0]  divisor;
    tag_t             tag;
  } div_req_t;

  typedef struct packed {
    logic [DIV_W-1:0] quotient;
    tag_t             tag;
  } div_rsp_t;

endpackage

[rtl/rrc_div.sv]
// Pipelined restoring divider, a few quotient bits per stage, with per-stage flow control.
module rrc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrc_pkg::div_req_t in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output rrc_pkg::div_rsp_t out_rsp
);

  localparam int NS = rrc_pkg::DIV_STAGES;
  localparam int DW = rrc_pkg::DIV_W;
  localparam int RW = rrc_pkg::MV_W;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] qd;
  } step_t;

  // Shift DIV_BITS dividend bits into the remainder, shift quotient bits in below
  function automatic step_t div_step(input logic [RW-1:0] rem, input logic [DW-1:0] qd,
                                     input logic [RW-1:0] d);
    logic [RW:0]   t;
    logic [RW-1:0] r;
    logic [DW-1:0] q;
    step_t         res;
    r = rem;
    q = qd;
    for (int i = 0; i < rrc_pkg::DIV_BITS; i++) begin
      t = {r, q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r    = RW'(t - {1'b0, d});
        q[0] = 1'b1;
      end else begin
        r = t[RW-1:0];
      end
    end
    res.rem = r;
    res.qd  = q;
    return res;
  endfunction

  logic [NS-1:0]   v_r;
  logic [RW-1:0]   rem_r [NS];
  logic [DW-1:0]   qd_r  [NS];
  logic [RW-1:0]   d_r   [NS];
  rrc_pkg::tag_t   tag_r [NS];

  logic [NS:0]     en;
  logic [NS-1:0]   src_v;
  logic [RW-1:0]   src_rem [NS];
  logic [DW-1:0]   src_qd  [NS];
  logic [RW-1:0]   src_d   [NS];
  rrc_pkg::tag_t   src_tag [NS];
  step_t           st_nxt  [NS];

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    src_v[0]   = in_valid;
    src_rem[0] = '0;
    src_qd[0]  = in_req.dividend;
    src_d[0]   = in_req.divisor;
    src_tag[0] = in_req.tag;
    for (int k = 1; k < NS; k++) begin
      src_v[k]   = v_r[k-1];
      src_rem[k] = rem_r[k-1];
      src_qd[k]  = qd_r[k-1];
      src_d[k]   = d_r[k-1];
      src_tag[k] = tag_r[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      st_nxt[k] = div_step(src_rem[k], src_qd[k], src_d[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= src_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        rem_r[k] <= st_nxt[k].rem;
        qd_r[k]  <= st_nxt[k].qd;
        d_r[k]   <= src_d[k];
        tag_r[k] <= src_tag[k];
      end
    end
  end

  assign in_ready         = en[0];
  assign out_valid        = v_r[NS-1];
  assign out_rsp.quotient = qd_r[NS-1];
  assign out_rsp.tag      = tag_r[NS-1];

endmodule

[rtl/ratiometric_resistance_calc.sv]
// Top level of the ratiometric resistance calculator: checks, products, divide, bias.
// Pipeline: 20 register stages between an accepted request and its offered result
//   (3 front stages: decode and rref*gain, partial products, sum; 13 divider stages of
//   4 quotient bits each; 4 back stages: saturate, bias scaling, reciprocal, output).
// Throughput: one request per cycle; every stage has its own valid bit and stalls only
//   when the stage after it is full, so bubbles are squeezed out under back-pressure.
// Reset (synchronous, rst_n low): all valid bits clear and the reference and gain
//   registers return to their defaults; payload registers are not reset.
module ratiometric_resistance_calc (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rrc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rrc_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [rrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration: per-range reference resistor and Q16 gain
  // ---------------------------------------------------------------------------
  logic [rrc_pkg::RREF_W-1:0] rref_r [4];
  logic [rrc_pkg::GAIN_W-1:0] gain_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rref_r[0] <= rrc_pkg::RREF1_RST;
      rref_r[1] <= rrc_pkg::RREF2_RST;
      rref_r[2] <= rrc_pkg::RREF3_RST;
      rref_r[3] <= rrc_pkg::RREF4_RST;
      gain_r[0] <= rrc_pkg::GAIN_RST;
      gain_r[1] <= rrc_pkg::GAIN_RST;
      gain_r[2] <= rrc_pkg::GAIN_RST;
      gain_r[3] <= rrc_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rrc_pkg::CFG_RREF1: rref_r[0] <= cfg_wdata;
        rrc_pkg::CFG_RREF2: rref_r[1] <= cfg_wdata;
        rrc_pkg::CFG_RREF3: rref_r[2] <= cfg_wdata;
        rrc_pkg::CFG_RREF4: rref_r[3] <= cfg_wdata;
        rrc_pkg::CFG_GAIN1: gain_r[0] <= cfg_wdata[rrc_pkg::GAIN_W-1:0];
        rrc_pkg::CFG_GAIN2: gain_r[1] <= cfg_wdata[rrc_pkg::GAIN_W-1:0];
        rrc_pkg::CFG_GAIN3: gain_r[2] <= cfg_wdata[rrc_pkg::GAIN_W-1:0];
        rrc_pkg::CFG_GAIN4: gain_r[3] <= cfg_wdata[rrc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: each stage advances when empty or when its successor advances
  // ---------------------------------------------------------------------------
  logic v_s0_r, v_s1_r, v_s2_r, v_p1_r, v_p2_r, v_p3_r, v_p4_r;
  logic en_s0, en_s1, en_s2, en_p1, en_p2, en_p3, en_p4;
  logic div_in_ready, div_out_valid;

  assign en_p4 = !v_p4_r || out_ready;
  assign en_p3 = !v_p3_r || en_p4;
  assign en_p2 = !v_p2_r || en_p3;
  assign en_p1 = !v_p1_r || en_p2;
  assign en_s2 = !v_s2_r || div_in_ready;
  assign en_s1 = !v_s1_r || en_s2;
  assign en_s0 = !v_s0_r || en_s1;
  assign in_ready = en_s0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s0_r <= 1'b0;
      v_s1_r <= 1'b0;
      v_s2_r <= 1'b0;
      v_p1_r <= 1'b0;
      v_p2_r <= 1'b0;
      v_p3_r <= 1'b0;
      v_p4_r <= 1'b0;
    end else begin
      if (en_s0) v_s0_r <= in_valid;
      if (en_s1) v_s1_r <= v_s0_r;
      if (en_s2) v_s2_r <= v_s1_r;
      if (en_p1) v_p1_r <= div_out_valid;
      if (en_p2) v_p2_r <= v_p1_r;
      if (en_p3) v_p3_r <= v_p2_r;
      if (en_p4) v_p4_r <= v_p3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // S0: classify the request, pick the range registers, form rref*gain and mv*1000
  // ---------------------------------------------------------------------------
  logic [1:0]                 sel_idx;
  rrc_pkg::tag_t              tag_s0_nxt, tag_s0_r;
  logic [rrc_pkg::RG_W-1:0]   rg_s0_r;
  logic [rrc_pkg::MVK_W-1:0]  mvk_s0_r;
  logic [rrc_pkg::MV_W-1:0]   diff_s0_r;

  // Range 1..4 maps to register slot 0..3; other codes carry an error status and their result is zeroed
  assign sel_idx = 2'(in_data.range_select - 3'd1);

  always_comb begin
    tag_s0_nxt.fault     = '0;
    tag_s0_nxt.low_range = (in_data.range_select == rrc_pkg::RANGE_LOW);
    if (in_data.range_select > rrc_pkg::RANGE_TOP) begin
      tag_s0_nxt.status = rrc_pkg::ST_BAD_RANGE;
    end else if (in_data.range_select == rrc_pkg::RANGE_AUTO) begin
      tag_s0_nxt.status = rrc_pkg::ST_NOT_IMPL;
    end else if (!in_data.sample_valid) begin
      tag_s0_nxt.status = rrc_pkg::ST_FAULT;
      tag_s0_nxt.fault  = in_data.sample_fault;
    end else if ({1'b0, in_data.supply_mv} <= {1'b0, in_data.measured_mv} + 14'd1) begin
      // headroom of 1 mV or less, including a measured voltage at or above supply
      tag_s0_nxt.status = rrc_pkg::ST_OVERRANGE;
    end else begin
      tag_s0_nxt.status = rrc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s0) begin
      tag_s0_r  <= tag_s0_nxt;
      rg_s0_r   <= rrc_pkg::RG_W'(rref_r[sel_idx]) * rrc_pkg::RG_W'(gain_r[sel_idx]);
      mvk_s0_r  <= rrc_pkg::MVK_W'(in_data.measured_mv) * rrc_pkg::MV_SCALE;
      diff_s0_r <= in_data.supply_mv - in_data.measured_mv;
    end
  end

  // ---------------------------------------------------------------------------
  // S1: two partial products of (rref*gain) * (mv*1000)
  // ---------------------------------------------------------------------------
  localparam int SP = rrc_pkg::PP_SPLIT;
  localparam int PW = rrc_pkg::PP_W;

  logic [PW-1:0]             pp_lo_s1_r, pp_hi_s1_r;
  logic [rrc_pkg::MV_W-1:0]  diff_s1_r;
  rrc_pkg::tag_t             tag_s1_r;

  always_ff @(posedge clk) begin
    if (en_s1) begin
      pp_lo_s1_r <= PW'(rg_s0_r[SP-1:0]) * PW'(mvk_s0_r);
      pp_hi_s1_r <= PW'(rg_s0_r[rrc_pkg::RG_W-1:SP]) * PW'(mvk_s0_r);
      diff_s1_r  <= diff_s0_r;
      tag_s1_r   <= tag_s0_r;
    end
  end

  // ---------------------------------------------------------------------------
  // S2: sum the partial products and drop the Q16 fraction; the floor of a floor
  //     keeps the quotient exact, so the divisor is the plain voltage difference
  // ---------------------------------------------------------------------------
  logic [rrc_pkg::PROD_W-1:0] prod_sum;
  rrc_pkg::div_req_t          req_s2_r;

  assign prod_sum = rrc_pkg::PROD_W'(pp_lo_s1_r) + (rrc_pkg::PROD_W'(pp_hi_s1_r) << SP);

  always_ff @(posedge clk) begin
    if (en_s2) begin
      req_s2_r.dividend <= rrc_pkg::DIV_W'(prod_sum[rrc_pkg::PROD_W-1:rrc_pkg::Q16_SHIFT]);
      req_s2_r.divisor  <= diff_s1_r;
      req_s2_r.tag      <= tag_s1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider
  // ---------------------------------------------------------------------------
  rrc_pkg::div_rsp_t div_rsp;

  rrc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_s2_r),
    .in_ready  (div_in_ready),
    .in_req    (req_s2_r),
    .out_valid (div_out_valid),
    .out_ready (en_p1),
    .out_rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // P1: saturate and locate the result against the low-range bias band
  // ---------------------------------------------------------------------------
  localparam int DW = rrc_pkg::DIV_W;
  localparam int RW = rrc_pkg::RES_W;

  logic [RW-1:0]            r_sat;
  logic [RW-1:0]            r_p1_r, r_p2_r, r_p3_r;
  logic                     flat_p1_r, band_p1_r, flat_p2_r, band_p2_r, flat_p3_r, band_p3_r;
  logic [rrc_pkg::BX_W-1:0] x_p1_r;
  rrc_pkg::tag_t            tag_p1_r, tag_p2_r, tag_p3_r;

  assign r_sat = (|div_rsp.quotient[DW-1:RW]) ? rrc_pkg::R_MAX : div_rsp.quotient[RW-1:0];

  always_ff @(posedge clk) begin
    if (en_p1) begin
      r_p1_r    <= r_sat;
      flat_p1_r <= (r_sat <= rrc_pkg::BIAS_LO_R);
      band_p1_r <= (r_sat < rrc_pkg::BIAS_HI_R);
      x_p1_r    <= rrc_pkg::BX_W'(rrc_pkg::BIAS_HI_R - r_sat);
      tag_p1_r  <= div_rsp.tag;
    end
  end

  // ---------------------------------------------------------------------------
  // P2: y = floor(161 * x / 64), the first factor of 8050 * x / 80000
  // ---------------------------------------------------------------------------
  logic [23:0]              bx_scaled;
  logic [rrc_pkg::BY_W-1:0] y_p2_r, y_p3_r;

  assign bx_scaled = 24'(x_p1_r) * rrc_pkg::BIAS_NUM;

  always_ff @(posedge clk) begin
    if (en_p2) begin
      y_p2_r    <= rrc_pkg::BY_W'(bx_scaled >> rrc_pkg::BIAS_SHIFT);
      r_p2_r    <= r_p1_r;
      flat_p2_r <= flat_p1_r;
      band_p2_r <= band_p1_r;
      tag_p2_r  <= tag_p1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // P3: estimate y / 25 by reciprocal; the estimate is the floor or one below
  // ---------------------------------------------------------------------------
  logic [rrc_pkg::BM_W-1:0] y_recip;
  logic [rrc_pkg::BQ_W-1:0] qe_p3_r;

  assign y_recip = rrc_pkg::BM_W'(y_p2_r) * rrc_pkg::RECIP_25;

  always_ff @(posedge clk) begin
    if (en_p3) begin
      qe_p3_r   <= rrc_pkg::BQ_W'(y_recip >> rrc_pkg::RECIP_SHIFT);
      y_p3_r    <= y_p2_r;
      r_p3_r    <= r_p2_r;
      flat_p3_r <= flat_p2_r;
      band_p3_r <= band_p2_r;
      tag_p3_r  <= tag_p2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // P4: correct the estimate, subtract the bias with a clamp at zero, and hold
  //     the finished result in the output register
  // ---------------------------------------------------------------------------
  logic [rrc_pkg::BY_W-1:0] bias_rem;
  logic [rrc_pkg::BQ_W-1:0] bias_q;
  logic [RW-1:0]            bias;
  rrc_pkg::out_t            out_nxt, out_r;

  always_comb begin
    bias_rem = y_p3_r - rrc_pkg::BIAS_DIV * rrc_pkg::BY_W'(qe_p3_r);
    bias_q   = (bias_rem >= rrc_pkg::BIAS_DIV) ? qe_p3_r + 1'b1 : qe_p3_r;
    if (flat_p3_r) begin
      bias = rrc_pkg::BIAS_FLAT;
    end else if (band_p3_r) begin
      bias = RW'(bias_q);
    end else begin
      bias = '0;
    end

    out_nxt.status     = tag_p3_r.status;
    out_nxt.fault_echo = tag_p3_r.fault;
    if (tag_p3_r.status != rrc_pkg::ST_OK) begin
      out_nxt.resistance_mohm = '0;
    end else if (!tag_p3_r.low_range) begin
      out_nxt.resistance_mohm = r_p3_r;
    end else if (r_p3_r > bias) begin
      out_nxt.resistance_mohm = r_p3_r - bias;
    end else begin
      out_nxt.resistance_mohm = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_p4_r;
  assign out_data  = out_r;

endmodule

[rtl/rrc_checker.sv]
// Port-level assertions for the ratiometric resistance calculator, bound to the top level.
module rrc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input rrc_pkg::in_t                   in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input rrc_pkg::out_t                  out_data
);

  // Hold a waiting request unchanged until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting request changed or withdrawn");

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Drop the resistance on every non-ok status
  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rrc_pkg::ST_OK |-> out_data.resistance_mohm == '0)
    else $error("resistance nonzero on error status");

  // Echo a fault code only with the sample fault status
  a_fault_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rrc_pkg::ST_FAULT |-> out_data.fault_echo == '0)
    else $error("fault code echoed without sample fault status");

  // Come out of reset with an empty pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind ratiometric_resistance_calc rrc_checker u_rrc_checker (.*);

[bench/ratiometric_resistance_calc_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the ratiometric resistance calculator: random traffic, stalls, checks.
module ratiometric_resistance_calc_tb;

  localparam int     CLK_HALF_NS  = 5;
  localparam int     RESET_CYCLES = 11;
  localparam int     MAX_IDLE     = 13;
  localparam int     DRAIN_CYCLES = 30;      // comfortably past the 20 stage pipeline
  localparam int     PHASES       = 9;
  localparam int     PHASE_ITEMS  = 148;
  localparam int     NUM_REGS     = 8;
  localparam longint TIMEOUT_NS   = 3_000_000;
  localparam int     MV_TOP       = (1 << rrc_pkg::MV_W) - 1;
  localparam int     RREF_TOP     = (1 << rrc_pkg::RREF_W) - 1;
  localparam logic [63:0] TAPER_SPAN = 64'd80000;  // width of the low-range bias taper

  // Range codes the package does not name
  localparam logic [rrc_pkg::RANGE_W-1:0] RANGE_2K      = 3'd2;
  localparam logic [rrc_pkg::RANGE_W-1:0] RANGE_20K     = 3'd3;
  localparam logic [rrc_pkg::RANGE_W-1:0] RANGE_INV_LO  = 3'd5;
  localparam logic [rrc_pkg::RANGE_W-1:0] RANGE_INV_MID = 3'd6;
  localparam logic [rrc_pkg::RANGE_W-1:0] RANGE_INV_HI  = 3'd7;

  typedef enum {CFG_NOMINAL, CFG_TOP, CFG_BOTTOM, CFG_RANDOM, CFG_ZERO_REF} cfg_mode_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  rrc_pkg::in_t                   in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rrc_pkg::out_t                  out_data;
  logic                           cfg_we    = 1'b0;
  logic [rrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rrc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  ratiometric_resistance_calc u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Our own copy of the reference and gain registers, kept in step with every write
  logic [rrc_pkg::RREF_W-1:0] rref_cfg [4];
  logic [rrc_pkg::GAIN_W-1:0] gain_cfg [4];

  rrc_pkg::in_t  sample_q  [$];   // requests waiting for the driver
  rrc_pkg::out_t reading_q [$];   // expected readings, oldest first

  logic         in_acc      = 1'b0;   // request accepted at the last rising edge
  logic         out_acc     = 1'b0;   // reading accepted at the last rising edge
  logic         in_idle_on  = 1'b1;
  logic         out_idle_on = 1'b1;
  int           open_cnt    = 0;      // accepted requests whose reading has not come yet
  int           mismatches  = 0;
  int           in_gap      = 0;
  int           out_stall   = 0;
  logic         nxt_valid;
  rrc_pkg::in_t nxt_req;

  initial begin
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Expected reading of one request under the current register copy.
  function automatic rrc_pkg::out_t calc_reading(rrc_pkg::in_t s);
    rrc_pkg::out_t              r;
    logic [rrc_pkg::RREF_W-1:0] rref;
    logic [rrc_pkg::GAIN_W-1:0] gain;
    logic [rrc_pkg::MV_W-1:0]   diff;
    logic [79:0]                num;
    logic [79:0]                den;
    logic [79:0]                quo;
    logic [rrc_pkg::RES_W-1:0]  mohm;
    logic [63:0]                bias;
    r.status          = rrc_pkg::ST_OK;
    r.fault_echo      = '0;
    r.resistance_mohm = '0;
    if (s.range_select > rrc_pkg::RANGE_TOP) begin
      r.status = rrc_pkg::ST_BAD_RANGE;
    end else if (s.range_select == rrc_pkg::RANGE_AUTO) begin
      r.status = rrc_pkg::ST_NOT_IMPL;
    end else if (!s.sample_valid) begin
      // pass the fault code through, zero included
      r.status     = rrc_pkg::ST_FAULT;
      r.fault_echo = s.sample_fault;
    end else if (int'(s.supply_mv) <= int'(s.measured_mv) + 1) begin
      r.status = rrc_pkg::ST_OVERRANGE;
    end else begin
      rref = rref_cfg[int'(s.range_select) - int'(rrc_pkg::RANGE_LOW)];
      gain = gain_cfg[int'(s.range_select) - int'(rrc_pkg::RANGE_LOW)];
      diff = s.supply_mv - s.measured_mv;
      num  = 80'(rref) * 80'(gain) * 80'(s.measured_mv) * 80'(rrc_pkg::MV_SCALE);
      den  = 80'(diff) << rrc_pkg::Q16_SHIFT;
      quo  = num / den;
      mohm = (quo > 80'(rrc_pkg::R_MAX)) ? rrc_pkg::R_MAX : quo[rrc_pkg::RES_W-1:0];
      if (s.range_select == rrc_pkg::RANGE_LOW) begin
        // flat bias up to 20 ohm, linear taper to zero at 100 ohm
        if (mohm <= rrc_pkg::BIAS_LO_R) begin
          bias = 64'(rrc_pkg::BIAS_FLAT);
        end else if (mohm < rrc_pkg::BIAS_HI_R) begin
          bias = (64'(rrc_pkg::BIAS_FLAT) * 64'(rrc_pkg::BIAS_HI_R - mohm)) / TAPER_SPAN;
        end else begin
          bias = '0;
        end
        mohm = (64'(mohm) > bias) ? mohm - rrc_pkg::RES_W'(bias) : '0;
      end
      r.resistance_mohm = mohm;
    end
    return r;
  endfunction

  // Random request: mostly well-formed measurements, the rest raw noise.
  function automatic rrc_pkg::in_t rand_sample();
    rrc_pkg::in_t s;
    int unsigned  pick;
    int unsigned  sup;
    int unsigned  off;
    s.range_select = rrc_pkg::RANGE_W'($urandom_range(0, 7));
    s.sample_valid = 1'($urandom_range(0, 1));
    s.sample_fault = rrc_pkg::FAULT_W'($urandom_range(0, 15));
    s.measured_mv  = rrc_pkg::MV_W'($urandom_range(0, MV_TOP));
    s.supply_mv    = rrc_pkg::MV_W'($urandom_range(0, MV_TOP));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      s.range_select = rrc_pkg::RANGE_W'($urandom_range(rrc_pkg::RANGE_LOW,
                                                         rrc_pkg::RANGE_TOP));
      s.sample_valid = 1'b1;
      sup = $urandom_range(2, MV_TOP);
      case (pick)
        4: begin
          // small ratio, lands range 1 inside the bias band
          s.measured_mv = rrc_pkg::MV_W'($urandom_range(0, (sup - 2) / 16));
        end
        5: begin
          // hug the headroom limit from both sides
          off = $urandom_range(0, 3);
          s.measured_mv = rrc_pkg::MV_W'((sup >= off) ? sup - off : 0);
        end
        6: begin
          s.measured_mv = rrc_pkg::MV_W'($urandom_range((sup - 2) / 2, sup - 2));
        end
        default: begin
          s.measured_mv = rrc_pkg::MV_W'($urandom_range(0, sup - 2));
        end
      endcase
      s.supply_mv = rrc_pkg::MV_W'(sup);
    end
    return s;
  endfunction

  function automatic void add_sample(logic [rrc_pkg::RANGE_W-1:0] rs, logic ok,
                                     logic [rrc_pkg::FAULT_W-1:0] f, int mv, int sup);
    rrc_pkg::in_t s;
    s.range_select = rs;
    s.sample_valid = ok;
    s.sample_fault = f;
    s.measured_mv  = rrc_pkg::MV_W'(mv);
    s.supply_mv    = rrc_pkg::MV_W'(sup);
    sample_q.push_back(s);
  endfunction

  function automatic logic [rrc_pkg::CFG_DATA_W-1:0] reg_value(cfg_mode_t mode, int idx);
    logic                           is_gain;
    logic [rrc_pkg::CFG_DATA_W-1:0] v;
    is_gain = (idx >= int'(rrc_pkg::CFG_GAIN1));
    case (mode)
      CFG_TOP: begin
        // all ones; gain registers keep only their low bits
        v = '1;
      end
      CFG_BOTTOM: begin
        v = is_gain ? '0 : rrc_pkg::CFG_DATA_W'(1);
      end
      CFG_RANDOM: begin
        if (!is_gain) begin
          v = rrc_pkg::CFG_DATA_W'($urandom_range(1, RREF_TOP));
        end else if ($urandom_range(0, 2) == 0) begin
          v = rrc_pkg::CFG_DATA_W'($urandom_range(int'(rrc_pkg::GAIN_RST) - 4096,
                                                  int'(rrc_pkg::GAIN_RST) + 4096));
        end else begin
          v = rrc_pkg::CFG_DATA_W'($urandom);
        end
      end
      CFG_ZERO_REF: begin
        v = is_gain ? rrc_pkg::CFG_DATA_W'($urandom) : '0;
      end
      default: begin
        case (idx)
          int'(rrc_pkg::CFG_RREF1): v = rrc_pkg::CFG_DATA_W'(rrc_pkg::RREF1_RST);
          int'(rrc_pkg::CFG_RREF2): v = rrc_pkg::CFG_DATA_W'(rrc_pkg::RREF2_RST);
          int'(rrc_pkg::CFG_RREF3): v = rrc_pkg::CFG_DATA_W'(rrc_pkg::RREF3_RST);
          int'(rrc_pkg::CFG_RREF4): v = rrc_pkg::CFG_DATA_W'(rrc_pkg::RREF4_RST);
          default:                  v = rrc_pkg::CFG_DATA_W'(rrc_pkg::GAIN_RST);
        endcase
      end
    endcase
    return v;
  endfunction

  // Write one register at the next falling edge and mirror it in the local copy.
  task automatic write_reg(int idx, logic [rrc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rrc_pkg::CFG_IDX_W'(idx);
    cfg_wdata <= val;
    if (idx < int'(rrc_pkg::CFG_GAIN1)) begin
      rref_cfg[idx - int'(rrc_pkg::CFG_RREF1)] = val[rrc_pkg::RREF_W-1:0];
    end else begin
      gain_cfg[idx - int'(rrc_pkg::CFG_GAIN1)] = val[rrc_pkg::GAIN_W-1:0];
    end
  endtask

  // Hold until every queued request is accepted and every reading is back, then let
  // the pipeline run dry. Sample at the rising edge so the driver's pop cannot race.
  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || open_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Request driver: hold a request until accepted, then wait the drawn gap and
  // advance to the next one. One nonblocking update per signal per edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_req   = in_data;
      if (in_valid && in_acc) begin
        nxt_valid = 1'b0;
        in_gap    = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (sample_q.size() != 0) begin
          nxt_req   = sample_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_req;
    end
  end

  // Reading sink: after each reading, stall the drawn number of cycles, counted only
  // while a reading is on offer so the stall always lands on one.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_acc) begin
        out_stall = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        if (out_valid) out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check each accepted reading against the oldest expectation, then
  // predict the reading of any request accepted at this edge.
  always @(posedge clk) begin
    int            delta;
    rrc_pkg::out_t want;
    if (!rst_n) begin
      in_acc   <= 1'b0;
      out_acc  <= 1'b0;
      open_cnt <= 0;
    end else begin
      delta = 0;
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reading: status %0d fault %0d mohm %0d", $time,
                   out_data.status, out_data.fault_echo, out_data.resistance_mohm);
        end else begin
          want  = reading_q.pop_front();
          delta = delta - 1;
          if (out_data.status !== want.status || out_data.fault_echo !== want.fault_echo ||
              out_data.resistance_mohm !== want.resistance_mohm) begin
            mismatches++;
            $display({"%0t: mismatch: expected status %0d fault %0d mohm %0d,",
                      " got status %0d fault %0d mohm %0d"},
                     $time, want.status, want.fault_echo, want.resistance_mohm,
                     out_data.status, out_data.fault_echo, out_data.resistance_mohm);
          end
        end
      end
      if (in_valid && in_ready) begin
        reading_q.push_back(calc_reading(in_data));
        delta = delta + 1;
      end
      in_acc   <= in_valid && in_ready;
      out_acc  <= out_valid && out_ready;
      open_cnt <= open_cnt + delta;
    end
  end

  // Stimulus: reset, then phases of register settings each followed by traffic.
  initial begin
    cfg_mode_t mode;
    rref_cfg[0] = rrc_pkg::RREF1_RST;
    rref_cfg[1] = rrc_pkg::RREF2_RST;
    rref_cfg[2] = rrc_pkg::RREF3_RST;
    rref_cfg[3] = rrc_pkg::RREF4_RST;
    for (int g = 0; g < 4; g++) gain_cfg[g] = rrc_pkg::GAIN_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       mode = CFG_TOP;
        2:       mode = CFG_BOTTOM;
        5:       mode = CFG_ZERO_REF;
        7:       mode = CFG_NOMINAL;
        default: mode = CFG_RANDOM;
      endcase
      // drain fully before touching registers; this is also the sender's long pause
      wait_idle();
      if (p != 0) begin
        for (int i = 0; i < NUM_REGS; i++) write_reg(i, reg_value(mode, i));
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      // one phase back to back, one with sender gaps only, one with sink stalls only
      in_idle_on  <= (p != 3 && p != 7);
      out_idle_on <= (p != 3 && p != 6);

      if (p == 0) begin
        // range and sample checks, in priority order
        add_sample(rrc_pkg::RANGE_AUTO, 1'b1, 4'd0,  100,  1000);
        add_sample(rrc_pkg::RANGE_AUTO, 1'b0, 4'd9,  100,  1000);
        add_sample(RANGE_INV_LO,        1'b1, 4'd0,  100,  1000);
        add_sample(RANGE_INV_MID,       1'b1, 4'd0,  0,    MV_TOP);
        add_sample(RANGE_INV_HI,        1'b0, 4'd15, MV_TOP, 0);
        add_sample(rrc_pkg::RANGE_LOW,  1'b0, 4'd0,  100,  1000);
        add_sample(rrc_pkg::RANGE_TOP,  1'b0, 4'd15, 100,  1000);
        add_sample(RANGE_20K,           1'b0, 4'd10, MV_TOP, 0);
        // headroom limits
        add_sample(RANGE_2K,            1'b1, 4'd0,  MV_TOP, MV_TOP);
        add_sample(RANGE_2K,            1'b1, 4'd0,  0,    0);
        add_sample(RANGE_20K,           1'b1, 4'd0,  0,    1);
        add_sample(RANGE_20K,           1'b1, 4'd0,  0,    2);
        add_sample(rrc_pkg::RANGE_TOP,  1'b1, 4'd0,  MV_TOP - 1, MV_TOP);
        add_sample(rrc_pkg::RANGE_TOP,  1'b1, 4'd15, MV_TOP - 2, MV_TOP);
        add_sample(rrc_pkg::RANGE_TOP,  1'b1, 4'd0,  MV_TOP, 100);
        // low-range bias: clamp at zero, flat part, both band edges, inside, above
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  0,    MV_TOP);
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  10,   1010);
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  20,   1020);
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  21,   1021);
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  50,   1050);
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  100,  1100);
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  MV_TOP - 2, MV_TOP);
        add_sample(RANGE_2K,            1'b1, 4'd0,  1,    MV_TOP);
        add_sample(RANGE_20K,           1'b1, 4'd0,  4095, MV_TOP);
      end else if (p == 1) begin
        // largest registers: drive every range into saturation, then ranges 1 and 4 at a small reading
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  MV_TOP - 2, MV_TOP);
        add_sample(RANGE_2K,            1'b1, 4'd0,  MV_TOP - 2, MV_TOP);
        add_sample(RANGE_20K,           1'b1, 4'd0,  MV_TOP - 2, MV_TOP);
        add_sample(rrc_pkg::RANGE_TOP,  1'b1, 4'd0,  MV_TOP - 2, MV_TOP);
        add_sample(rrc_pkg::RANGE_LOW,  1'b1, 4'd0,  1,    MV_TOP);
        add_sample(rrc_pkg::RANGE_TOP,  1'b1, 4'd0,  1,    MV_TOP);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) sample_q.push_back(rand_sample());
    end

    wait_idle();
    if (mismatches == 0 && open_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if the block hangs or drops a reading.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d readings outstanding", $time, open_cnt);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
